/* design/vsa_pkg.sv */
package vsa_pkg;

  // Slot store geometry
  localparam int VOICE_SLOTS = 16;
  localparam int SLOT_W      = $clog2(VOICE_SLOTS);

  // Field widths
  localparam int KEY_W    = 16;
  localparam int TIME_W   = 32;
  localparam int VOL_W    = 16;
  localparam int FIN_W    = 4;
  localparam int OSLOT_W  = 4;
  localparam int GAIN_W   = 16;
  localparam int AGE_W    = TIME_W + 1;
  localparam int ENTRY_W  = KEY_W + TIME_W;
  localparam int GM_W     = 2 * VOL_W;
  localparam int PROD_W   = GM_W + VOL_W;
  localparam int GAIN_SH  = 30;
  localparam int SAT_W    = PROD_W - GAIN_SH;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd32768;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_MASTER  = 1'b0;
  localparam logic REG_EFFECTS = 1'b1;

  // Operation codes
  localparam logic OP_PLAY   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Outcome codes
  localparam logic [1:0] OUT_REPLAY  = 2'd0;
  localparam logic [1:0] OUT_FILL    = 2'd1;
  localparam logic [1:0] OUT_REPLACE = 2'd2;
  localparam logic [1:0] OUT_NONE    = 2'd3;

  typedef struct packed {
    logic [VOL_W-1:0] master;
    logic [VOL_W-1:0] effects;
  } vsa_cfg_t;

endpackage

/* design/vsa_in_if.sv */
interface vsa_in_if import vsa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               operation;
  logic [KEY_W-1:0]   sound_key;
  logic [TIME_W-1:0]  now_seconds;
  logic [VOL_W-1:0]   request_volume;
  logic [FIN_W-1:0]   finished_voice;

  modport source (
    output valid, operation, sound_key, now_seconds, request_volume, finished_voice,
    input  ready
  );
  modport sink (
    input  valid, operation, sound_key, now_seconds, request_volume, finished_voice,
    output ready
  );
endinterface

/* design/vsa_out_if.sv */
interface vsa_out_if import vsa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OSLOT_W-1:0] voice_slot;
  logic [1:0]         outcome;
  logic               copy_valid;
  logic [OSLOT_W-1:0] copy_slot;
  logic [GAIN_W-1:0]  drive_gain;

  modport source (
    output valid, voice_slot, outcome, copy_valid, copy_slot, drive_gain,
    input  ready
  );
  modport sink (
    input  valid, voice_slot, outcome, copy_valid, copy_slot, drive_gain,
    output ready
  );
endinterface

/* design/voice_slot_allocator_lru_top.sv */
// Channel   Direction  Handshake         Word
// in_ch     sink       valid / ready     operation, sound_key, now_seconds,
//                                        request_volume, finished_voice
// out_ch    source     valid / ready     voice_slot, outcome, copy_valid,
//                                        copy_slot, drive_gain
// APB       slave      psel / penable    master_volume @0x0, effects_volume @0x4
//
// A finished event gives no output word.
// A play request scans the slot memory, which has one read port, so the scan
// covers one slot per cycle and stops at the first idle match or the first
// empty slot.
// Reset is synchronous; the used and active marks clear at once, no clearing pass.
// The output register holds a word until taken; a finished scan waits for it.
module voice_slot_allocator_lru_top import vsa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  vsa_in_if.sink            in_ch,
  vsa_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  vsa_cfg_t          cfg;
  logic [VOL_W-1:0]  req_vol;
  logic [GAIN_W-1:0] gain;

  vsa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vsa_gain u_gain (
    .clk  (clk),
    .cfg  (cfg),
    .vol  (req_vol),
    .gain (gain)
  );

  vsa_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .gain    (gain),
    .req_vol (req_vol)
  );

  // A finished event never produces a word
  a_finish_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.operation == OP_FINISH)) |=> !$rose(out_ch.valid))
    else $error("finished event produced an output word");

  // A play request holds off the next word until its word is handed to the output register
  a_play_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.operation == OP_PLAY)) |=> !in_ch.ready)
    else $error("input accepted during a scan");

  // No voice means a zero slot, no copy and zero gain
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.outcome == OUT_NONE)) |->
      ((out_ch.voice_slot == '0) && !out_ch.copy_valid && (out_ch.drive_gain == '0)))
    else $error("no-voice word carries a payload");

  // A copy source is reported on replacement only
  a_copy_replace: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.copy_valid) |-> (out_ch.outcome == OUT_REPLACE))
    else $error("copy source outside replacement");

  // Gain never exceeds unity
  a_gain_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.drive_gain <= GAIN_UNITY))
    else $error("gain above unity");

endmodule

/* design/vsa_ram.sv */
module vsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/vsa_cfg.sv */
module vsa_cfg import vsa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output vsa_cfg_t          cfg
);

  logic [VOL_W-1:0] master_r, master_nxt;
  logic [VOL_W-1:0] effects_r, effects_nxt;
  logic             wr_en;
  logic             reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[CFG_AW-1];

  // Decode the register write
  always_comb begin
    master_nxt  = master_r;
    effects_nxt = effects_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_MASTER:  master_nxt  = pwdata[VOL_W-1:0];
        REG_EFFECTS: effects_nxt = pwdata[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r  <= GAIN_UNITY;
      effects_r <= GAIN_UNITY;
    end else begin
      master_r  <= master_nxt;
      effects_r <= effects_nxt;
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_MASTER:  prdata = CFG_DW'(master_r);
      REG_EFFECTS: prdata = CFG_DW'(effects_r);
      default:     prdata = '0;
    endcase
  end

  assign cfg.master  = master_r;
  assign cfg.effects = effects_r;

endmodule

/* design/vsa_gain.sv */
module vsa_gain import vsa_pkg::*; (
  input  logic              clk,
  input  vsa_cfg_t          cfg,
  input  logic [VOL_W-1:0]  vol,
  output logic [GAIN_W-1:0] gain
);

  logic [GM_W-1:0]   gm_r;
  logic [PROD_W-1:0] prod_r;
  logic [SAT_W-1:0]  shifted;
  logic [GAIN_W-1:0] gain_r;

  assign shifted = prod_r[PROD_W-1:GAIN_SH];

  // Master times effects, then times the request volume, then scale and clamp
  always_ff @(posedge clk) begin
    gm_r   <= GM_W'(cfg.master) * GM_W'(cfg.effects);
    prod_r <= PROD_W'(gm_r) * PROD_W'(vol);
    gain_r <= (shifted > SAT_W'(GAIN_UNITY)) ? GAIN_UNITY : shifted[GAIN_W-1:0];
  end

  assign gain = gain_r;

endmodule

/* design/vsa_scan.sv */
module vsa_scan import vsa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  vsa_in_if.sink            in_ch,
  vsa_out_if.source         out_ch,
  input  logic [GAIN_W-1:0] gain,
  output logic [VOL_W-1:0]  req_vol
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_POST = 2'd2;

  localparam logic [SLOT_W:0]   CNT_END  = (SLOT_W+1)'(VOICE_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(VOICE_SLOTS - 1);

  // Control state
  logic [1:0]             state_r, state_nxt;
  logic [SLOT_W:0]        rd_cnt_r, rd_cnt_nxt;
  logic                   ev_vld_r, ev_vld_nxt;
  logic [SLOT_W-1:0]      ev_idx_r, ev_idx_nxt;
  logic [VOICE_SLOTS-1:0] used_r, used_nxt;
  logic [VOICE_SLOTS-1:0] active_r, active_nxt;
  logic                   out_vld_r, out_vld_nxt;

  // Scan bookkeeping and request payload
  logic                    copy_fnd_r, copy_fnd_nxt;
  logic [SLOT_W-1:0]       copy_idx_r, copy_idx_nxt;
  logic                    repl_fnd_r, repl_fnd_nxt;
  logic [SLOT_W-1:0]       repl_idx_r, repl_idx_nxt;
  logic signed [AGE_W-1:0] oldest_r, oldest_nxt;
  logic [KEY_W-1:0]        key_r;
  logic [TIME_W-1:0]       now_r;
  logic [VOL_W-1:0]        vol_r;

  // Pending result
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [1:0]        res_outcome_r, res_outcome_nxt;
  logic              res_copy_v_r, res_copy_v_nxt;
  logic [SLOT_W-1:0] res_copy_slot_r, res_copy_slot_nxt;

  // Output register
  logic [OSLOT_W-1:0] o_slot_r, o_slot_nxt;
  logic [1:0]         o_outcome_r, o_outcome_nxt;
  logic               o_copy_v_r, o_copy_v_nxt;
  logic [OSLOT_W-1:0] o_copy_slot_r, o_copy_slot_nxt;
  logic [GAIN_W-1:0]  o_gain_r, o_gain_nxt;

  // Slot memory: key and load time
  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;

  logic                    accept;
  logic                    scan_done;
  logic [KEY_W-1:0]        ev_key;
  logic [TIME_W-1:0]       ev_time;
  logic                    ev_used;
  logic                    ev_act;
  logic                    ev_match;
  logic signed [AGE_W-1:0] ev_age;

  vsa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (VOICE_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_cnt_r[SLOT_W-1:0]),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign req_vol     = vol_r;

  // Decode the slot under evaluation
  assign ev_key   = ram_rdata[ENTRY_W-1:TIME_W];
  assign ev_time  = ram_rdata[TIME_W-1:0];
  assign ev_used  = used_r[ev_idx_r];
  assign ev_act   = active_r[ev_idx_r];
  assign ev_match = ev_used && (ev_key == key_r);
  assign ev_age   = $signed({1'b0, now_r}) - $signed({1'b0, ev_time});

  // Sequencer: during a scan, one read issued and one slot evaluated per cycle
  always_comb begin
    state_nxt         = state_r;
    rd_cnt_nxt        = rd_cnt_r;
    ev_vld_nxt        = ev_vld_r;
    ev_idx_nxt        = ev_idx_r;
    used_nxt          = used_r;
    active_nxt        = active_r;
    copy_fnd_nxt      = copy_fnd_r;
    copy_idx_nxt      = copy_idx_r;
    repl_fnd_nxt      = repl_fnd_r;
    repl_idx_nxt      = repl_idx_r;
    oldest_nxt        = oldest_r;
    res_slot_nxt      = res_slot_r;
    res_outcome_nxt   = res_outcome_r;
    res_copy_v_nxt    = res_copy_v_r;
    res_copy_slot_nxt = res_copy_slot_r;
    out_vld_nxt       = out_vld_r && !out_ch.ready;
    o_slot_nxt        = o_slot_r;
    o_outcome_nxt     = o_outcome_r;
    o_copy_v_nxt      = o_copy_v_r;
    o_copy_slot_nxt   = o_copy_slot_r;
    o_gain_nxt        = o_gain_r;
    ram_we            = 1'b0;
    ram_waddr         = ev_idx_r;
    ram_wdata         = {key_r, now_r};
    scan_done         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.operation == OP_FINISH) begin
            // Drop the active mark of a slot that exists
            if (32'(in_ch.finished_voice) < VOICE_SLOTS) begin
              active_nxt[SLOT_W'(in_ch.finished_voice)] = 1'b0;
            end
          end else begin
            state_nxt    = ST_SCAN;
            rd_cnt_nxt   = '0;
            ev_vld_nxt   = 1'b0;
            copy_fnd_nxt = 1'b0;
            copy_idx_nxt = '0;
            repl_fnd_nxt = 1'b0;
            repl_idx_nxt = '0;
            oldest_nxt   = '0;
          end
        end
      end

      ST_SCAN: begin
        // Issue the next read
        if (rd_cnt_r < CNT_END) begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
          ev_vld_nxt = 1'b1;
          ev_idx_nxt = rd_cnt_r[SLOT_W-1:0];
        end else begin
          ev_vld_nxt = 1'b0;
        end

        // Evaluate the slot read last cycle
        if (ev_vld_r) begin
          priority if (ev_match && !ev_act) begin
            active_nxt[ev_idx_r] = 1'b1;
            res_slot_nxt         = ev_idx_r;
            res_outcome_nxt      = OUT_REPLAY;
            res_copy_v_nxt       = 1'b0;
            res_copy_slot_nxt    = '0;
            scan_done            = 1'b1;
          end else if (ev_match) begin
            copy_fnd_nxt = 1'b1;
            copy_idx_nxt = ev_idx_r;
          end else if (!ev_used) begin
            used_nxt[ev_idx_r]   = 1'b1;
            active_nxt[ev_idx_r] = 1'b1;
            ram_we               = 1'b1;
            ram_waddr            = ev_idx_r;
            res_slot_nxt         = ev_idx_r;
            res_outcome_nxt      = OUT_FILL;
            res_copy_v_nxt       = 1'b0;
            res_copy_slot_nxt    = '0;
            scan_done            = 1'b1;
          end else if (!ev_act && (ev_age > oldest_r)) begin
            repl_fnd_nxt = 1'b1;
            repl_idx_nxt = ev_idx_r;
            oldest_nxt   = ev_age;
          end else begin
          end

          // End of scan: replace the oldest idle slot or give nothing
          if (!scan_done && (ev_idx_r == LAST_IDX)) begin
            scan_done = 1'b1;
            if (repl_fnd_nxt) begin
              used_nxt[repl_idx_nxt]   = 1'b1;
              active_nxt[repl_idx_nxt] = 1'b1;
              ram_we                   = 1'b1;
              ram_waddr                = repl_idx_nxt;
              res_slot_nxt             = repl_idx_nxt;
              res_outcome_nxt          = OUT_REPLACE;
              res_copy_v_nxt           = copy_fnd_nxt;
              res_copy_slot_nxt        = copy_fnd_nxt ? copy_idx_nxt : '0;
            end else begin
              res_slot_nxt      = '0;
              res_outcome_nxt   = OUT_NONE;
              res_copy_v_nxt    = 1'b0;
              res_copy_slot_nxt = '0;
            end
          end
        end

        if (scan_done) begin
          state_nxt = ST_POST;
        end
      end

      ST_POST: begin
        // Hand the word to the output register once it is free
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt     = 1'b1;
          o_slot_nxt      = OSLOT_W'(res_slot_r);
          o_outcome_nxt   = res_outcome_r;
          o_copy_v_nxt    = res_copy_v_r;
          o_copy_slot_nxt = OSLOT_W'(res_copy_slot_r);
          o_gain_nxt      = (res_outcome_r == OUT_NONE) ? '0 : gain;
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_cnt_r  <= '0;
      ev_vld_r  <= 1'b0;
      used_r    <= '0;
      active_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_cnt_r  <= rd_cnt_nxt;
      ev_vld_r  <= ev_vld_nxt;
      used_r    <= used_nxt;
      active_r  <= active_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_ch.sound_key;
      now_r <= in_ch.now_seconds;
      vol_r <= in_ch.request_volume;
    end
    ev_idx_r        <= ev_idx_nxt;
    copy_fnd_r      <= copy_fnd_nxt;
    copy_idx_r      <= copy_idx_nxt;
    repl_fnd_r      <= repl_fnd_nxt;
    repl_idx_r      <= repl_idx_nxt;
    oldest_r        <= oldest_nxt;
    res_slot_r      <= res_slot_nxt;
    res_outcome_r   <= res_outcome_nxt;
    res_copy_v_r    <= res_copy_v_nxt;
    res_copy_slot_r <= res_copy_slot_nxt;
    o_slot_r        <= o_slot_nxt;
    o_outcome_r     <= o_outcome_nxt;
    o_copy_v_r      <= o_copy_v_nxt;
    o_copy_slot_r   <= o_copy_slot_nxt;
    o_gain_r        <= o_gain_nxt;
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.voice_slot = o_slot_r;
  assign out_ch.outcome    = o_outcome_r;
  assign out_ch.copy_valid = o_copy_v_r;
  assign out_ch.copy_slot  = o_copy_slot_r;
  assign out_ch.drive_gain = o_gain_r;

endmodule
